>>> rtl/cd32_pkg.sv
// Shared types, codes and helper functions for the CD32 pad shift register.
// Used by cd32_core and by the top level cd32_pad_shift_register_with_detect.
package cd32_pkg;

  // Highest shift index from which a clock edge still shifts out the next bit.
  localparam int unsigned CD32_LAST_SHIFT_INDEX = 9;
  localparam int unsigned CD32_COUNT_WIDTH      = 16;
  localparam int unsigned CD32_BIT_W            = 4;
  localparam int unsigned CD32_WORD_W           = 10;
  localparam int unsigned CD32_CFG_W            = 16;

  localparam logic [CD32_CFG_W-1:0] CD32_HOLDOFF_RST   = 16'd500;
  localparam logic [CD32_CFG_W-1:0] CD32_WINDOW_RST    = 16'd100;
  localparam logic [CD32_CFG_W-1:0] CD32_MIN_LATCH_RST = 16'd5;
  localparam logic [CD32_CFG_W-1:0] CD32_MIN_CLOCK_RST = 16'd5;

  typedef enum logic [2:0] {
    CMD_REPORT  = 3'd0,
    CMD_LATCH   = 3'd1,
    CMD_CLOCK   = 3'd2,
    CMD_TICK    = 3'd3,
    CMD_RESTART = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_HOLDOFF   = 2'd0,
    CFG_WINDOW    = 2'd1,
    CFG_MIN_LATCH = 2'd2,
    CFG_MIN_CLOCK = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] pad_buttons;
    logic [7:0] extra_buttons;
    logic       latch_level;
    logic [2:0] pin_latches;
  } item_t;

  typedef struct packed {
    logic [CD32_CFG_W-1:0] holdoff_ticks;
    logic [CD32_CFG_W-1:0] window_ticks;
    logic [CD32_CFG_W-1:0] min_latch_edges;
    logic [CD32_CFG_W-1:0] min_clock_edges;
  } cfg_t;

  typedef struct packed {
    logic       data_level;
    logic       data_drive;
    logic [2:0] restore_lines;
    logic       restore_valid;
    logic [3:0] dir_lines;
    logic       dir_valid;
    logic       cd32_mode;
    logic       mode_changed;
    logic       detecting;
  } result_t;

  // Map the report bytes onto the serial button word; bits 8 and 9 are the ID bits.
  function automatic logic [CD32_WORD_W-1:0] map_buttons(logic [7:0] pad, logic [7:0] extra);
    return {2'b11, 1'b0, (extra[5] | extra[4]), extra[0], extra[1],
            pad[7], pad[4], pad[6], pad[5]};
  endfunction

  // Bits above the top of the word read as zero.
  function automatic logic word_bit(logic [CD32_WORD_W-1:0] word, logic [CD32_BIT_W-1:0] idx);
    logic [(1 << CD32_BIT_W)-1:0] ext;
    ext = (1 << CD32_BIT_W)'(word);
    return ext[idx];
  endfunction

endpackage

>>> rtl/cd32_core.sv
// State and next-result logic of the CD32 pad: button word, shift index,
// detection window and mode. Depends on cd32_pkg.
module cd32_core import cd32_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = CD32_COUNT_WIDTH
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  localparam logic [1:0] PH_HOLDOFF = 2'd0;
  localparam logic [1:0] PH_WINDOW  = 2'd1;
  localparam logic [1:0] PH_DONE    = 2'd2;
  localparam int unsigned CMP_W = (COUNT_WIDTH > CD32_CFG_W) ? COUNT_WIDTH : CD32_CFG_W;

  logic [CD32_WORD_W-1:0] button_q, button_d;
  logic [CD32_WORD_W-1:0] latched_q, latched_d;
  logic [CD32_BIT_W-1:0]  idx_q, idx_d, idx_inc;
  logic [2:0]             saved_q, saved_d;
  logic                   mode_q, mode_d;
  logic [1:0]             phase_q, phase_d;
  logic [CD32_CFG_W-1:0]  timer_q, timer_d, timer_inc;
  logic [COUNT_WIDTH-1:0] lcnt_q, lcnt_d, lcnt_inc;
  logic [COUNT_WIDTH-1:0] ccnt_q, ccnt_d, ccnt_inc;
  logic [3:0]             dir_q, dir_d;
  logic                   want_cd32;
  result_t                res;

  assign timer_inc = (timer_q == '1) ? timer_q : timer_q + 1'b1;
  assign lcnt_inc  = (lcnt_q == '1) ? lcnt_q : lcnt_q + 1'b1;
  assign ccnt_inc  = (ccnt_q == '1) ? ccnt_q : ccnt_q + 1'b1;
  assign idx_inc   = idx_q + 1'b1;
  assign want_cd32 = (CMP_W'(lcnt_q) >= CMP_W'(cfg_i.min_latch_edges)) &&
                     (CMP_W'(ccnt_q) >= CMP_W'(cfg_i.min_clock_edges));

  always_comb begin
    button_d  = button_q;
    latched_d = latched_q;
    idx_d     = idx_q;
    saved_d   = saved_q;
    mode_d    = mode_q;
    phase_d   = phase_q;
    timer_d   = timer_q;
    lcnt_d    = lcnt_q;
    ccnt_d    = ccnt_q;
    dir_d     = dir_q;
    res       = '0;
    res.data_level = 1'b1;

    unique case (item_i.cmd)
      CMD_REPORT: begin
        button_d      = map_buttons(item_i.pad_buttons, item_i.extra_buttons);
        dir_d         = ~item_i.pad_buttons[3:0];
        res.dir_valid = 1'b1;
      end
      CMD_LATCH: begin
        if (phase_q == PH_WINDOW) begin
          lcnt_d = lcnt_inc;
        end else if (mode_q) begin
          if (!item_i.latch_level) begin
            latched_d      = button_q;
            idx_d          = '0;
            saved_d        = item_i.pin_latches;
            res.data_level = ~button_q[0];
            res.data_drive = 1'b1;
          end else begin
            res.restore_lines = saved_q;
            res.restore_valid = 1'b1;
          end
        end
      end
      CMD_CLOCK: begin
        if (phase_q == PH_WINDOW) begin
          ccnt_d = ccnt_inc;
        end else if (mode_q && (idx_q <= CD32_BIT_W'(CD32_LAST_SHIFT_INDEX))) begin
          idx_d          = idx_inc;
          res.data_level = ~word_bit(latched_q, idx_inc);
          res.data_drive = 1'b1;
        end
      end
      CMD_TICK: begin
        if (phase_q == PH_HOLDOFF) begin
          timer_d = timer_inc;
          if (timer_inc >= cfg_i.holdoff_ticks) begin
            phase_d = PH_WINDOW;
            timer_d = '0;
            lcnt_d  = '0;
            ccnt_d  = '0;
          end
        end else if (phase_q == PH_WINDOW) begin
          timer_d = timer_inc;
          if (timer_inc >= cfg_i.window_ticks) begin
            phase_d = PH_DONE;
            if (want_cd32 != mode_q) begin
              mode_d           = want_cd32;
              res.mode_changed = 1'b1;
            end
          end
        end
      end
      CMD_RESTART: begin
        phase_d = PH_HOLDOFF;
        timer_d = '0;
        lcnt_d  = '0;
        ccnt_d  = '0;
        if (mode_q) begin
          mode_d           = 1'b0;
          res.mode_changed = 1'b1;
        end
      end
      default: begin
        // Unused command codes only report status.
      end
    endcase

    res.dir_lines = dir_d;
    res.cd32_mode = mode_d;
    res.detecting = (phase_d == PH_WINDOW);
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      button_q  <= '0;
      latched_q <= '0;
      idx_q     <= '0;
      saved_q   <= '0;
      mode_q    <= 1'b0;
      phase_q   <= PH_HOLDOFF;
      timer_q   <= '0;
      lcnt_q    <= '0;
      ccnt_q    <= '0;
      dir_q     <= '1;
    end else if (step_i) begin
      button_q  <= button_d;
      latched_q <= latched_d;
      idx_q     <= idx_d;
      saved_q   <= saved_d;
      mode_q    <= mode_d;
      phase_q   <= phase_d;
      timer_q   <= timer_d;
      lcnt_q    <= lcnt_d;
      ccnt_q    <= ccnt_d;
      dir_q     <= dir_d;
    end
  end

  a_mode_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res.mode_changed |=> mode_q != $past(mode_q))
    else $error("mode_changed reported without a mode switch");

  a_restart_holdoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (item_i.cmd == CMD_RESTART) |=> (phase_q == PH_HOLDOFF) && !mode_q)
    else $error("restart did not return to hold-off in joystick mode");

  a_restore_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (res.restore_valid || res.data_drive) |-> mode_q && (phase_q != PH_WINDOW))
    else $error("pin activity outside CD32 shift mode");

endmodule

>>> rtl/cd32_pad_shift_register_with_detect.sv
// Top level of the CD32 pad shift register with protocol detection:
// input register, configuration registers, result register. Uses cd32_pkg, cd32_core.
//
// Usage:
// Events (pad report, latch edge, clock edge, millisecond tick, restart)
// enter on the input channel: a transfer happens when in_valid_i is high and
// in_stall_o is low. Each event gives exactly one result on the output
// channel, transferred when out_valid_o is high and out_stall_i is low.
// An event is held first in the input register, then in the result register.
// One event is taken every cycle while the receiver does not stall; the state
// update is a single pass of logic between the two registers. When the
// receiver stalls, the result register holds its result and the input register
// holds the next event; in_stall_o rises only once both are full. The
// configuration channel (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i)
// is always ready; it is to be written while no event is in flight, and the
// block itself does not enforce this. Reset sets the valid flags low, the
// configuration registers to their default values and the core state to
// joystick mode, hold-off phase, counters zero and direction lines released.
module cd32_pad_shift_register_with_detect import cd32_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = CD32_COUNT_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            cmd_i,
  input  logic [7:0]            pad_buttons_i,
  input  logic [7:0]            extra_buttons_i,
  input  logic                  latch_level_i,
  input  logic [2:0]            pin_latches_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  data_level_o,
  output logic                  data_drive_o,
  output logic [2:0]            restore_lines_o,
  output logic                  restore_valid_o,
  output logic [3:0]            dir_lines_o,
  output logic                  dir_valid_o,
  output logic                  cd32_mode_o,
  output logic                  mode_changed_o,
  output logic                  detecting_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [CD32_CFG_W-1:0] cfg_data_i
);

  logic    in_valid_q;
  item_t   item_q;
  logic    out_valid_q;
  result_t result_q;
  result_t core_res;
  cfg_t    cfg_q;
  logic    advance;
  logic    step;

  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= '{cmd: cmd_i, pad_buttons: pad_buttons_i, extra_buttons: extra_buttons_i,
                  latch_level: latch_level_i, pin_latches: pin_latches_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.holdoff_ticks   <= CD32_HOLDOFF_RST;
      cfg_q.window_ticks    <= CD32_WINDOW_RST;
      cfg_q.min_latch_edges <= CD32_MIN_LATCH_RST;
      cfg_q.min_clock_edges <= CD32_MIN_CLOCK_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_HOLDOFF:   cfg_q.holdoff_ticks   <= cfg_data_i;
        CFG_WINDOW:    cfg_q.window_ticks    <= cfg_data_i;
        CFG_MIN_LATCH: cfg_q.min_latch_edges <= cfg_data_i;
        CFG_MIN_CLOCK: cfg_q.min_clock_edges <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  cd32_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .item_i  (item_q),
    .cfg_i   (cfg_q),
    .result_o(core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      result_q <= core_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign data_level_o    = result_q.data_level;
  assign data_drive_o    = result_q.data_drive;
  assign restore_lines_o = result_q.restore_lines;
  assign restore_valid_o = result_q.restore_valid;
  assign dir_lines_o     = result_q.dir_lines;
  assign dir_valid_o     = result_q.dir_valid;
  assign cd32_mode_o     = result_q.cd32_mode;
  assign mode_changed_o  = result_q.mode_changed;
  assign detecting_o     = result_q.detecting;

  a_idle_data_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !data_drive_o |-> data_level_o)
    else $error("data level low without a data transfer");

  a_restore_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !restore_valid_o |-> (restore_lines_o == 3'd0))
    else $error("restore lines set without restore_valid");

  a_report_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && (item_q.cmd == CMD_REPORT) |=> out_valid_o && dir_valid_o)
    else $error("pad report did not produce a direction update");

endmodule

>>> dv/testbench.sv
// Self-checking testbench for cd32_pad_shift_register_with_detect.
// Holds its own model of the pad shift register and detection window and compares every
// transfer on the result channel; depends on cd32_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module testbench;
  import cd32_pkg::*;

  localparam logic [2:0] CMD_BAD_FIRST = 3'd5;
  localparam logic [2:0] CMD_BAD_LAST  = 3'd7;
  localparam int unsigned N_DIRECTED   = 26;
  localparam int unsigned TICK_MAX     = 65535;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef enum logic [1:0] {DET_HOLDOFF, DET_WINDOW, DET_DONE} det_phase_e;

  typedef struct {
    bit      cfg_row;
    cfg_t    cfg;
    item_t   ev;
    bit      typed;
    result_t want;
  } directed_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [2:0]            cmd_i;
  logic [7:0]            pad_buttons_i;
  logic [7:0]            extra_buttons_i;
  logic                  latch_level_i;
  logic [2:0]            pin_latches_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  data_level_o;
  logic                  data_drive_o;
  logic [2:0]            restore_lines_o;
  logic                  restore_valid_o;
  logic [3:0]            dir_lines_o;
  logic                  dir_valid_o;
  logic                  cd32_mode_o;
  logic                  mode_changed_o;
  logic                  detecting_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [1:0]            cfg_index_i;
  logic [CD32_CFG_W-1:0] cfg_data_i;

  cd32_pad_shift_register_with_detect dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .pad_buttons_i   (pad_buttons_i),
    .extra_buttons_i (extra_buttons_i),
    .latch_level_i   (latch_level_i),
    .pin_latches_i   (pin_latches_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .data_level_o    (data_level_o),
    .data_drive_o    (data_drive_o),
    .restore_lines_o (restore_lines_o),
    .restore_valid_o (restore_valid_o),
    .dir_lines_o     (dir_lines_o),
    .dir_valid_o     (dir_valid_o),
    .cd32_mode_o     (cd32_mode_o),
    .mode_changed_o  (mode_changed_o),
    .detecting_o     (detecting_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // Model state of the shift register and the detector.
  cfg_t                   cur_cfg;
  logic [CD32_WORD_W-1:0] pad_word;
  logic [CD32_WORD_W-1:0] shift_word;
  int unsigned            shift_index;
  logic [2:0]             saved_lines;
  logic                   cd32_on;
  det_phase_e             det_phase;
  int unsigned            det_timer;
  longint unsigned        latch_edges;
  longint unsigned        clock_edges;
  logic [3:0]             dir_now;

  result_t     pad_results_due [$];
  int unsigned mismatches;
  int unsigned events_sent;
  int unsigned sender_idle_pct;
  int unsigned recv_idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic longint unsigned bump_count(longint unsigned v);
    longint unsigned top;
    top = (64'd1 << CD32_COUNT_WIDTH) - 1;
    return (v >= top) ? top : v + 1;
  endfunction

  function automatic void reset_pad_model();
    cur_cfg     = '{CD32_HOLDOFF_RST, CD32_WINDOW_RST, CD32_MIN_LATCH_RST, CD32_MIN_CLOCK_RST};
    pad_word    = '0;
    shift_word  = '0;
    shift_index = 0;
    saved_lines = '0;
    cd32_on     = 1'b0;
    det_phase   = DET_HOLDOFF;
    det_timer   = 0;
    latch_edges = 0;
    clock_edges = 0;
    dir_now     = 4'hF;
  endfunction

  // Advances the model by one event and returns the status it shows.
  function automatic result_t predict_pad_step(item_t ev);
    result_t                r;
    logic [CD32_WORD_W-1:0] w;
    logic                   want_cd32;
    r = '0;
    r.data_level = 1'b1;
    case (ev.cmd)
      CMD_REPORT: begin
        w = '0;
        w[0] = ev.pad_buttons[5];
        w[1] = ev.pad_buttons[6];
        w[2] = ev.pad_buttons[4];
        w[3] = ev.pad_buttons[7];
        w[4] = ev.extra_buttons[1];
        w[5] = ev.extra_buttons[0];
        w[6] = |ev.extra_buttons[5:4];
        w[8] = 1'b1;
        w[9] = 1'b1;
        pad_word = w;
        dir_now = ~ev.pad_buttons[3:0];
        r.dir_valid = 1'b1;
      end
      CMD_LATCH: begin
        if (det_phase == DET_WINDOW) begin
          latch_edges = bump_count(latch_edges);
        end else if (cd32_on) begin
          if (!ev.latch_level) begin
            shift_word = pad_word;
            shift_index = 0;
            saved_lines = ev.pin_latches;
            r.data_level = ~shift_word[0];
            r.data_drive = 1'b1;
          end else begin
            r.restore_lines = saved_lines;
            r.restore_valid = 1'b1;
          end
        end
      end
      CMD_CLOCK: begin
        if (det_phase == DET_WINDOW) begin
          clock_edges = bump_count(clock_edges);
        end else if (cd32_on && shift_index <= CD32_LAST_SHIFT_INDEX) begin
          shift_index++;
          // Past the top of the word the bit reads as zero, so the pin goes high.
          r.data_level = (shift_index < CD32_WORD_W) ? ~shift_word[shift_index] : 1'b1;
          r.data_drive = 1'b1;
        end
      end
      CMD_TICK: begin
        if (det_phase == DET_HOLDOFF) begin
          if (det_timer < TICK_MAX) det_timer++;
          if (det_timer >= cur_cfg.holdoff_ticks) begin
            det_phase = DET_WINDOW;
            det_timer = 0;
            latch_edges = 0;
            clock_edges = 0;
          end
        end else if (det_phase == DET_WINDOW) begin
          if (det_timer < TICK_MAX) det_timer++;
          if (det_timer >= cur_cfg.window_ticks) begin
            want_cd32 = (latch_edges >= cur_cfg.min_latch_edges) &&
                        (clock_edges >= cur_cfg.min_clock_edges);
            det_phase = DET_DONE;
            if (want_cd32 != cd32_on) begin
              cd32_on = want_cd32;
              r.mode_changed = 1'b1;
            end
          end
        end
      end
      CMD_RESTART: begin
        det_phase = DET_HOLDOFF;
        det_timer = 0;
        latch_edges = 0;
        clock_edges = 0;
        if (cd32_on) begin
          cd32_on = 1'b0;
          r.mode_changed = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.dir_lines = dir_now;
    r.cd32_mode = cd32_on;
    r.detecting = (det_phase == DET_WINDOW);
    return r;
  endfunction

  function automatic item_t ev_of(logic [2:0] cmd, logic [7:0] pad, logic [7:0] extra,
                                  logic lvl, logic [2:0] pins);
    return '{cmd, pad, extra, lvl, pins};
  endfunction

  function automatic result_t status_of(logic dl, logic dd, logic [2:0] rl, logic rv,
                                        logic [3:0] dir, logic dv, logic mode, logic chg,
                                        logic det);
    return '{dl, dd, rl, rv, dir, dv, mode, chg, det};
  endfunction

  function automatic item_t make_event(logic [2:0] cmd);
    return ev_of(cmd, 8'($urandom), 8'($urandom), 1'($urandom), 3'($urandom));
  endfunction

  function automatic string show_result(result_t r);
    return $sformatf("dl=%b dd=%b rl=%0d rv=%b dir=%h dv=%b mode=%b chg=%b det=%b",
                     r.data_level, r.data_drive, r.restore_lines, r.restore_valid,
                     r.dir_lines, r.dir_valid, r.cd32_mode, r.mode_changed, r.detecting);
  endfunction

  // Offers one event, with random gaps, and books its expected status on transfer.
  task automatic send_event(input item_t ev, input bit typed = 1'b0,
                            input result_t want = '0);
    result_t r;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    cmd_i           <= ev.cmd;
    pad_buttons_i   <= ev.pad_buttons;
    extra_buttons_i <= ev.extra_buttons;
    latch_level_i   <= ev.latch_level;
    pin_latches_i   <= ev.pin_latches;
    do @(posedge clk_i); while (in_stall_o);
    r = predict_pad_step(ev);
    pad_results_due.push_back(typed ? want : r);
    events_sent++;
  endtask

  task automatic stop_events();
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pad_results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CD32_CFG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic program_cfg(input cfg_t c);
    stop_events();
    wait_drained();
    write_reg(CFG_HOLDOFF, c.holdoff_ticks);
    write_reg(CFG_WINDOW, c.window_ticks);
    write_reg(CFG_MIN_LATCH, c.min_latch_edges);
    write_reg(CFG_MIN_CLOCK, c.min_clock_edges);
    cfg_valid_i <= 1'b0;
    cur_cfg = c;
  endtask

  // One read-out of the pad: a report, falling latch, a run of clocks with occasional unknown codes, rising latch.
  task automatic shift_frame();
    item_t       ev;
    int unsigned clocks;
    clocks = $urandom_range(0, 12);
    send_event(make_event(CMD_REPORT));
    ev = make_event(CMD_LATCH);
    ev.latch_level = 1'b0;
    send_event(ev);
    repeat (clocks) begin
      if ($urandom_range(99) < 10) send_event(make_event(CMD_BAD_FIRST + 3'($urandom_range(2))));
      send_event(make_event(CMD_CLOCK));
    end
    ev = make_event(CMD_LATCH);
    ev.latch_level = 1'b1;
    send_event(ev);
  endtask

  task automatic play_session();
    int unsigned tick_pct;
    int unsigned pick;
    tick_pct = $urandom_range(5, 60);
    repeat ($urandom_range(0, 3)) send_event(make_event(3'($urandom)));
    send_event(make_event(CMD_RESTART));
    while (det_phase == DET_HOLDOFF)
      send_event(make_event(($urandom_range(99) < 85) ? CMD_TICK : CMD_REPORT));
    while (det_phase == DET_WINDOW) begin
      pick = $urandom_range(99);
      if (pick < tick_pct) send_event(make_event(CMD_TICK));
      else if (pick < tick_pct + 5) send_event(make_event(CMD_REPORT));
      else send_event(make_event($urandom_range(1) ? CMD_LATCH : CMD_CLOCK));
    end
    repeat ($urandom_range(1, 3)) shift_frame();
    if ($urandom_range(1)) send_event(make_event(CMD_TICK));
  endtask

  task automatic run_sessions(input int unsigned n);
    int unsigned first;
    int unsigned sessions;
    first = events_sent;
    sessions = 0;
    while (events_sent - first < n) begin
      play_session();
      sessions++;
      // Hold the sender back once until the pipeline has emptied.
      if (sessions == 1) begin
        stop_events();
        wait_drained();
      end
    end
  endtask

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{data_level_o, data_drive_o, restore_lines_o, restore_valid_o, dir_lines_o,
              dir_valid_o, cd32_mode_o, mode_changed_o, detecting_o};
      if (pad_results_due.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: result with nothing pending: %s", $realtime, show_result(got));
        mismatches++;
      end else begin
        want = pad_results_due.pop_front();
        if (got !== want) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: expected %s, got %s", $realtime, show_result(want),
                     show_result(got));
          mismatches++;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    directed_row_t directed_rows [N_DIRECTED];
    result_t       quiet;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    cmd_i           = CMD_REPORT;
    pad_buttons_i   = '0;
    extra_buttons_i = '0;
    latch_level_i   = 1'b0;
    pin_latches_i   = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CFG_HOLDOFF;
    cfg_data_i      = '0;
    mismatches      = 0;
    events_sent     = 0;
    sender_idle_pct = 7;
    recv_idle_pct   = 47;
    reset_pad_model();

    // In joystick mode before the window, edges, ticks and unknown codes only show the status.
    quiet = status_of(1'b1, 1'b0, 3'd0, 1'b0, 4'h0, 1'b0, 1'b0, 1'b0, 1'b0);
    directed_rows = '{
      '{1'b0, '0, ev_of(CMD_REPORT, 8'h00, 8'h00, 1'b0, 3'd0), 1'b1,
        status_of(1'b1, 1'b0, 3'd0, 1'b0, 4'hF, 1'b1, 1'b0, 1'b0, 1'b0)},
      '{1'b0, '0, ev_of(CMD_REPORT, 8'hFF, 8'hFF, 1'b1, 3'd7), 1'b1,
        status_of(1'b1, 1'b0, 3'd0, 1'b0, 4'h0, 1'b1, 1'b0, 1'b0, 1'b0)},
      '{1'b0, '0, ev_of(CMD_LATCH, 8'h00, 8'h00, 1'b0, 3'd7), 1'b1, quiet},
      '{1'b0, '0, ev_of(CMD_LATCH, 8'hFF, 8'hFF, 1'b1, 3'd0), 1'b1, quiet},
      '{1'b0, '0, ev_of(CMD_CLOCK, 8'h00, 8'h00, 1'b0, 3'd0), 1'b1, quiet},
      '{1'b0, '0, ev_of(CMD_BAD_FIRST, 8'hFF, 8'hFF, 1'b1, 3'd7), 1'b1, quiet},
      '{1'b0, '0, ev_of(CMD_BAD_LAST, 8'h00, 8'h00, 1'b0, 3'd0), 1'b1, quiet},
      '{1'b0, '0, ev_of(CMD_TICK, 8'h00, 8'h00, 1'b0, 3'd0), 1'b1, quiet},
      // Zero hold-off, zero window and zero thresholds: CD32 on the second tick.
      '{1'b1, '{16'd0, 16'd0, 16'd0, 16'd0}, '0, 1'b0, '0},
      '{1'b0, '0, ev_of(CMD_TICK, 8'h00, 8'h00, 1'b0, 3'd0), 1'b1,
        status_of(1'b1, 1'b0, 3'd0, 1'b0, 4'h0, 1'b0, 1'b0, 1'b0, 1'b1)},
      '{1'b0, '0, ev_of(CMD_TICK, 8'h00, 8'h00, 1'b0, 3'd0), 1'b1,
        status_of(1'b1, 1'b0, 3'd0, 1'b0, 4'h0, 1'b0, 1'b1, 1'b1, 1'b0)},
      '{1'b0, '0, ev_of(CMD_REPORT, 8'h50, 8'h01, 1'b0, 3'd0), 1'b0, '0},
      '{1'b0, '0, ev_of(CMD_LATCH, 8'h00, 8'h00, 1'b0, 3'd5), 1'b0, '0},
      // Eleven clocks: ten shift out bits 1 to 10, where bit 10 is past the end; the last one shifts nothing.
      '{1'b0, '0, ev_of(CMD_CLOCK, 8'h00, 8'h00, 1'b0, 3'd0), 1'b0, '0},
      '{1'b0, '0, ev_of(CMD_CLOCK, 8'h00, 8'h00, 1'b0, 3'd0), 1'b0, '0},
      '{1'b0, '0, ev_of(CMD_CLOCK, 8'h00, 8'h00, 1'b0, 3'd0), 1'b0, '0},
      '{1'b0, '0, ev_of(CMD_CLOCK, 8'h00, 8'h00, 1'b0, 3'd0), 1'b0, '0},
      '{1'b0, '0, ev_of(CMD_CLOCK, 8'h00, 8'h00, 1'b0, 3'd0), 1'b0, '0},
      '{1'b0, '0, ev_of(CMD_CLOCK, 8'h00, 8'h00, 1'b0, 3'd0), 1'b0, '0},
      '{1'b0, '0, ev_of(CMD_CLOCK, 8'h00, 8'h00, 1'b0, 3'd0), 1'b0, '0},
      '{1'b0, '0, ev_of(CMD_CLOCK, 8'h00, 8'h00, 1'b0, 3'd0), 1'b0, '0},
      '{1'b0, '0, ev_of(CMD_CLOCK, 8'h00, 8'h00, 1'b0, 3'd0), 1'b0, '0},
      '{1'b0, '0, ev_of(CMD_CLOCK, 8'h00, 8'h00, 1'b0, 3'd0), 1'b0, '0},
      '{1'b0, '0, ev_of(CMD_CLOCK, 8'h00, 8'h00, 1'b0, 3'd0), 1'b0, '0},
      '{1'b0, '0, ev_of(CMD_LATCH, 8'h00, 8'h00, 1'b1, 3'd2), 1'b1,
        status_of(1'b1, 1'b0, 3'd5, 1'b1, 4'hF, 1'b0, 1'b1, 1'b0, 1'b0)},
      '{1'b0, '0, ev_of(CMD_RESTART, 8'h00, 8'h00, 1'b0, 3'd0), 1'b1,
        status_of(1'b1, 1'b0, 3'd0, 1'b0, 4'hF, 1'b0, 1'b0, 1'b1, 1'b0)}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg_row) program_cfg(directed_rows[i].cfg);
      else send_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);
    end

    program_cfg('{16'd2, 16'd6, 16'd2, 16'd3});
    run_sessions(110);

    sender_idle_pct = 47;
    recv_idle_pct   = 7;
    program_cfg('{16'($urandom_range(0, 4)), 16'($urandom_range(0, 8)),
                  16'($urandom_range(0, 6)), 16'($urandom_range(0, 6))});
    run_sessions(110);

    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    program_cfg('{16'd1, 16'd4, 16'd0, 16'd0});
    run_sessions(110);

    // Largest settings: the hold-off never runs out here.
    program_cfg('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_event(make_event(CMD_RESTART));
    repeat (20) send_event(make_event(3'($urandom)));

    // A one-tick window with the largest thresholds: a handful of edges cannot
    // reach them, so the window closes in joystick mode.
    program_cfg('{16'd0, 16'd1, 16'hFFFF, 16'hFFFF});
    send_event(make_event(CMD_RESTART));
    send_event(make_event(CMD_TICK));
    repeat (6) send_event(make_event(CMD_LATCH));
    repeat (6) send_event(make_event(CMD_CLOCK));
    send_event(make_event(CMD_TICK));
    shift_frame();

    stop_events();
    wait_drained();
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> files.f
rtl/cd32_pkg.sv
rtl/cd32_core.sv
rtl/cd32_pad_shift_register_with_detect.sv
dv/testbench.sv
